// File: design/sgs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shearsort grid sorter.
// No dependencies; imported by the compare-exchange unit and the top level.
package sgs_pkg;

	// Fixed widths of the external fields.
	localparam int VALUE_W = 16;
	localparam int COORD_W = 3;

	// Direction of one compare-exchange.
	typedef enum logic {
		DIR_ASC  = 1'b0,
		DIR_DESC = 1'b1
	} cmp_dir_t;

endpackage

// File: design/shearsort_grid_sorter_unit.sv
`timescale 1ns / 1ps
// Shearsort grid sorter top level; uses sgs_pkg, sgs_ram, sgs_cmp_exch.
// Load: one cycle per input transaction; stall stays low only while loading.
// Sort: (2*P+1)*N*(N-1)^2 compare-exchanges, P = clog2(N)+1, each a read and a compare, plus a
// write-back on a swap (one shared compare unit on one grid RAM).
// Drain: read, load, hold until taken; 64 results for N=8. Async reset to idle/loading.
module shearsort_grid_sorter_unit #(
	parameter int GRID_SIDE  = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sgs_pkg::VALUE_W-1:0]   value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sgs_pkg::VALUE_W-1:0]   value_res,
	output logic        [sgs_pkg::COORD_W-1:0]   row,
	output logic        [sgs_pkg::COORD_W-1:0]   column,
	output logic                                 last
);
	import sgs_pkg::*;

	localparam int CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = $clog2(GRID_SIDE);
	// full row+column phases; one extra row phase follows them
	localparam int PHASES = $clog2(GRID_SIDE) + 1;
	localparam int PH_W   = $clog2(PHASES + 1);

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_LOAD      = 7'b0000001,
		S_RD        = 7'b0000010,
		S_CMP       = 7'b0000100,
		S_WB        = 7'b0001000,
		S_EMIT_RD   = 7'b0010000,
		S_EMIT_LD   = 7'b0100000,
		S_EMIT_WAIT = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    load_q;     // cells loaded into the current grid
	logic [PH_W-1:0]      phase_q;    // shearsort phase, last one is row-only
	logic                 col_q;      // 0: row half of the phase, 1: column half
	logic [IDX_W-1:0]     line_q;     // row or column under sort
	logic [IDX_W-1:0]     pass_q;     // bubble pass within the line
	logic [IDX_W-1:0]     pos_q;      // pair position within the pass
	logic [IDX_W-1:0]     er_q;       // drain row
	logic [IDX_W-1:0]     ek_q;       // drain step within the row
	logic signed [DATA_WIDTH-1:0] hi_q;  // second value of a swapped pair

	logic                 out_valid_q;
	logic signed [VALUE_W-1:0] value_res_q;
	logic [COORD_W-1:0]   row_q;
	logic [COORD_W-1:0]   column_q;
	logic                 last_q;

	// grid RAM and compare unit hookup
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic signed [DATA_WIDTH-1:0] ram_wdata;
	logic [ADDR_W-1:0]            ram_raddr_a;
	logic signed [DATA_WIDTH-1:0] rd_a;
	logic signed [DATA_WIDTH-1:0] rd_b;
	logic signed [DATA_WIDTH-1:0] value_ext;
	logic [ADDR_W-1:0]            addr_a;
	logic [ADDR_W-1:0]            addr_b;
	logic [ADDR_W-1:0]            emit_addr;
	logic [IDX_W-1:0]             emit_col;
	cmp_dir_t                     cx_dir;
	logic                         cx_swap;
	logic signed [DATA_WIDTH-1:0] cx_first;
	logic signed [DATA_WIDTH-1:0] cx_second;

	// step bookkeeping
	logic pos_end, pass_end, line_end, sort_done, emit_last, take_out;

	// Narrow widths keep the low bits with sign, wide ones sign-extend.
	assign value_ext = DATA_WIDTH'(value);

	assign in_stall  = (state_q != S_LOAD);
	assign out_valid = out_valid_q;
	assign value_res = value_res_q;
	assign row       = row_q;
	assign column    = column_q;
	assign last      = last_q;
	assign take_out  = out_valid_q && !out_stall;

	// Pair addresses: neighbors in a row, or one row apart in a column.
	always_comb begin
		if (col_q) begin
			addr_a = ADDR_W'(pos_q) * ADDR_W'(GRID_SIDE) + ADDR_W'(line_q);
			addr_b = addr_a + ADDR_W'(GRID_SIDE);
		end else begin
			addr_a = ADDR_W'(line_q) * ADDR_W'(GRID_SIDE) + ADDR_W'(pos_q);
			addr_b = addr_a + ADDR_W'(1);
		end
	end

	// Odd rows sort descending so the final read-out is a snake.
	assign cx_dir = (!col_q && line_q[0]) ? DIR_DESC : DIR_ASC;

	assign pos_end   = (pos_q == IDX_W'(GRID_SIDE - 2));
	assign pass_end  = (pass_q == IDX_W'(GRID_SIDE - 2));
	assign line_end  = (line_q == IDX_W'(GRID_SIDE - 1));
	assign sort_done = pos_end && pass_end && line_end && !col_q &&
		(phase_q == PH_W'(PHASES));

	// Snake drain: even rows left to right, odd rows right to left.
	assign emit_col  = er_q[0] ? (IDX_W'(GRID_SIDE - 1) - ek_q) : ek_q;
	assign emit_addr = ADDR_W'(er_q) * ADDR_W'(GRID_SIDE) + ADDR_W'(emit_col);
	assign emit_last = (er_q == IDX_W'(GRID_SIDE - 1)) && (ek_q == IDX_W'(GRID_SIDE - 1));

	// RAM port steering: load writes, swap writes (first in compare, second in write-back), drain reads.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = load_q;
		ram_wdata = value_ext;
		case (state_q)
			S_LOAD: begin
				ram_we = in_valid;
			end
			S_CMP: begin
				ram_we    = cx_swap;
				ram_waddr = addr_a;
				ram_wdata = cx_first;
			end
			S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = addr_b;
				ram_wdata = hi_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr_a = (state_q == S_EMIT_RD) ? emit_addr : addr_a;
	end

	sgs_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CELLS)
	) u_grid_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (rd_a),
		.raddr_b (addr_b),
		.rdata_b (rd_b)
	);

	sgs_cmp_exch #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_cmp_exch (
		.a_val      (rd_a),
		.b_val      (rd_b),
		.dir        (cx_dir),
		.swap       (cx_swap),
		.first_val  (cx_first),
		.second_val (cx_second)
	);

	// Sequencer: load, then bubble passes over every line, then drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_q      <= '0;
			phase_q     <= '0;
			col_q       <= 1'b0;
			line_q      <= '0;
			pass_q      <= '0;
			pos_q       <= '0;
			er_q        <= '0;
			ek_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_q == ADDR_W'(CELLS - 1)) begin
							load_q  <= '0;
							state_q <= S_RD;
						end else begin
							load_q <= load_q + ADDR_W'(1);
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP, S_WB: begin
					if (state_q == S_CMP && cx_swap) begin
						state_q <= S_WB;
					end else begin
						state_q <= sort_done ? S_EMIT_RD : S_RD;
						if (pos_end) begin
							pos_q <= '0;
							if (pass_end) begin
								pass_q <= '0;
								if (line_end) begin
									line_q <= '0;
									if (!col_q) begin
										if (sort_done) begin
											phase_q <= '0;
										end else begin
											col_q <= 1'b1;
										end
									end else begin
										col_q   <= 1'b0;
										phase_q <= phase_q + PH_W'(1);
									end
								end else begin
									line_q <= line_q + IDX_W'(1);
								end
							end else begin
								pass_q <= pass_q + IDX_W'(1);
							end
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (emit_last) begin
							er_q    <= '0;
							ek_q    <= '0;
							state_q <= S_LOAD;
						end else begin
							if (ek_q == IDX_W'(GRID_SIDE - 1)) begin
								ek_q <= '0;
								er_q <= er_q + IDX_W'(1);
							end else begin
								ek_q <= ek_q + IDX_W'(1);
							end
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Payload registers: swap holding value and the result transaction.
	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			hi_q <= cx_second;
		end
		if (state_q == S_EMIT_LD) begin
			value_res_q <= VALUE_W'(rd_a);
			row_q       <= COORD_W'(er_q);
			column_q    <= COORD_W'(emit_col);
			last_q      <= emit_last;
		end
	end

`ifndef SYNTHESIS
	// A write-back always follows a compare that decided to swap.
	a_wb_after_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> ($past(state_q) == S_CMP && $past(cx_swap)))
		else $error("write-back without a swap");

	// The grid RAM is never written while results are drained.
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(state_q == S_EMIT_RD || state_q == S_EMIT_LD ||
			state_q == S_EMIT_WAIT))
		else $error("grid written during drain");

	// Taking the final result returns the block to loading a fresh grid.
	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(take_out && last_q) |=> (state_q == S_LOAD && load_q == '0))
		else $error("no return to loading after last result");

	// A result is offered only from the drain wait state.
	a_valid_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_EMIT_WAIT))
		else $error("result offered outside drain");

	// Pair counters stay inside the line during sorting.
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_WB) |->
			(pos_q <= IDX_W'(GRID_SIDE - 2) && pass_q <= IDX_W'(GRID_SIDE - 2)))
		else $error("pair counter out of range");
`endif

endmodule

// File: design/sgs_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module sgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: design/sgs_cmp_exch.sv
`timescale 1ns / 1ps
// Shared compare-exchange unit: orders one pair of signed values.
// Depends on sgs_pkg (cmp_dir_t).
module sgs_cmp_exch #(
	parameter int DATA_WIDTH = 16
) (
	input  logic signed [DATA_WIDTH-1:0] a_val,
	input  logic signed [DATA_WIDTH-1:0] b_val,
	input  sgs_pkg::cmp_dir_t            dir,
	output logic                         swap,
	output logic signed [DATA_WIDTH-1:0] first_val,
	output logic signed [DATA_WIDTH-1:0] second_val
);
	import sgs_pkg::*;

	always_comb begin
		case (dir)
			DIR_ASC:  swap = (a_val > b_val);
			DIR_DESC: swap = (a_val < b_val);
			default:  swap = 1'b0;
		endcase
		first_val  = swap ? b_val : a_val;
		second_val = swap ? a_val : b_val;
	end

endmodule
